[design/linked_buffer_pool_manager_unit_assert.svh]
// Assertion macros shared by the linked buffer pool manager
`ifndef LINKED_BUFFER_POOL_MANAGER_UNIT_ASSERT_SVH
`define LINKED_BUFFER_POOL_MANAGER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define LBPM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define LBPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lbpm_pkg.sv]
// Types and constants of the linked buffer pool manager
`default_nettype none

package lbpm_pkg;

    localparam int HANDLE_W    = 6;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int ENTRIES_W   = 7;
    localparam int MAX_HANDLES = 1 << HANDLE_W;

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MEMBER_ERR = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] handle;
        logic                at_front;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]  out_handle;
        logic                 out_valid;
        logic [STATUS_W-1:0]  status;
        logic [ENTRIES_W-1:0] entries;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_PICK,
        S_PUT_LINK,
        S_PUT_FIX,
        S_UNLINK,
        S_FINISH
    } state_t;

    // Link memory read address source
    typedef enum logic [1:0] {
        RD_NONE,
        RD_HEAD,
        RD_HANDLE,
        RD_PREV
    } rd_sel_t;

    // Source of the selected entry
    typedef enum logic [1:0] {
        PICK_HOLD,
        PICK_HEAD,
        PICK_HANDLE,
        PICK_PREV
    } pick_sel_t;

    // Link update step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUT_SELF,
        OP_PUT_NEW,
        OP_PUT_FIX,
        OP_UNLINK
    } link_op_t;

    // Controller to datapath
    typedef struct packed {
        logic      idle;
        logic      capture;
        rd_sel_t   rd_sel;
        pick_sel_t pick_sel;
        link_op_t  op;
        logic      load_out;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             front;
        logic             err;
        logic             empty;
        logic             pool_empty;
        logic             out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[design/linked_buffer_pool_manager_unit.sv]
// Linked buffer pool manager: a circular doubly linked list of buffer handles.
// Errors, empty pools, peek at head and put into an empty pool go from lookup
// straight to finish; get at head and remove pass unlink, peek at the last entry
// passes pick, put into a non-empty pool passes put-link and put-fix, and get of
// the last entry passes pick and unlink. One request at a time: the next is taken only
// after the result is registered. Reset clears head, count and membership bits.
`default_nettype none

`include "linked_buffer_pool_manager_unit_assert.svh"

module linked_buffer_pool_manager_unit
    import lbpm_pkg::*;
#(
    parameter int NUM_HANDLES = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    ctrl_t    ctl;
    dp_stat_t stat;

    // Sequencer
    lbpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Link storage and pool state
    lbpm_dp #(
        .NUM_HANDLES (NUM_HANDLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    // Requests are taken only while the sequencer is idle
    assign req_stall = !ctl.idle;

    // Checks
    `LBPM_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "lbpm: request taken while busy")
    `LBPM_ASSERT_IMPLY(a_ret_is_ok, rsp_valid && rsp_data.out_valid, rsp_data.status == ST_OK, "lbpm: returned handle with bad status")
    `LBPM_ASSERT_IMPLY(a_no_ret_zero, rsp_valid && !rsp_data.out_valid, rsp_data.out_handle == '0, "lbpm: stray handle on result")
    `LBPM_ASSERT_IMPLY(a_entries_bound, rsp_valid, int'(rsp_data.entries) <= NUM_HANDLES, "lbpm: pool count beyond pool size")

endmodule

`default_nettype wire

[design/lbpm_ctrl.sv]
// Sequencing state machine of the linked buffer pool manager
`default_nettype none

module lbpm_ctrl
    import lbpm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire dp_stat_t stat,
    output ctrl_t         ctl
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (stat.err || stat.empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    case (stat.cmd) inside
                        CMD_PUT:
                        begin
                            state_next = stat.pool_empty ? S_FINISH : S_PUT_LINK;
                        end
                        CMD_GET, CMD_PEEK:
                        begin
                            if (!stat.front)
                            begin
                                state_next = S_PICK;
                            end
                            else if (stat.cmd == CMD_GET)
                            begin
                                state_next = S_UNLINK;
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_UNLINK;
                        end
                    endcase
                end
            end
            S_PICK:
            begin
                state_next = (stat.cmd == CMD_GET) ? S_UNLINK : S_FINISH;
            end
            S_PUT_LINK:
            begin
                state_next = S_PUT_FIX;
            end
            S_PUT_FIX:
            begin
                state_next = S_FINISH;
            end
            S_UNLINK:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        ctl.idle     = 1'b0;
        ctl.capture  = 1'b0;
        ctl.rd_sel   = RD_NONE;
        ctl.pick_sel = PICK_HOLD;
        ctl.op       = OP_NONE;
        ctl.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.idle    = 1'b1;
                ctl.capture = req_valid;
            end
            S_LOOKUP:
            begin
                if (!(stat.err || stat.empty))
                begin
                    case (stat.cmd) inside
                        CMD_PUT:
                        begin
                            if (stat.pool_empty)
                            begin
                                ctl.op = OP_PUT_SELF;
                            end
                            else
                            begin
                                ctl.rd_sel = RD_HEAD;
                            end
                        end
                        CMD_GET, CMD_PEEK:
                        begin
                            // head pick, or fetch the entry before the head
                            ctl.rd_sel = RD_HEAD;
                            if (stat.front)
                            begin
                                ctl.pick_sel = PICK_HEAD;
                            end
                        end
                        default:
                        begin
                            ctl.pick_sel = PICK_HANDLE;
                            ctl.rd_sel   = RD_HANDLE;
                        end
                    endcase
                end
            end
            S_PICK:
            begin
                ctl.pick_sel = PICK_PREV;
                if (stat.cmd == CMD_GET)
                begin
                    ctl.rd_sel = RD_PREV;
                end
            end
            S_PUT_LINK:
            begin
                ctl.op = OP_PUT_NEW;
            end
            S_PUT_FIX:
            begin
                ctl.op = OP_PUT_FIX;
            end
            S_UNLINK:
            begin
                ctl.op = OP_UNLINK;
            end
            S_FINISH:
            begin
                ctl.load_out = stat.out_free;
            end
            default:
            begin
                ctl.idle = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/lbpm_dp.sv]
// Datapath: link memories, head, count, membership bits and result register
`default_nettype none

module lbpm_dp
    import lbpm_pkg::*;
#(
    parameter int NUM_HANDLES = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire req_t  req_data,
    input  wire logic  rsp_stall,
    input  wire ctrl_t ctl,
    output dp_stat_t   stat,
    output logic       rsp_valid,
    output rsp_t       rsp_data
);

    // Only handles that fit the handle field can ever be members
    localparam int MEMB_N = (NUM_HANDLES < MAX_HANDLES) ? NUM_HANDLES : MAX_HANDLES;
    localparam int IDX_W  = $clog2(MEMB_N);
    localparam int CNT_W  = $clog2(MEMB_N + 1);

    typedef logic [IDX_W-1:0] idx_t;

    // Latched request and its classification
    req_t              req_reg;
    logic              err_reg;
    logic              empty_reg;

    // Pool state
    idx_t              head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [MEMB_N-1:0] member_reg;

    // Working registers
    idx_t              pick_reg;
    idx_t              last_reg;
    idx_t              next_rd_reg;
    idx_t              prev_rd_reg;

    // Result register
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    // Link memories
    idx_t              next_mem [MEMB_N];
    idx_t              prev_mem [MEMB_N];

    idx_t              req_idx;
    idx_t              in_idx;
    logic              in_ok;
    logic              in_member;
    logic              in_err;
    logic              in_empty;
    logic              count_gt1;
    logic              is_ret;
    rsp_t              rsp_next;

    idx_t              rd_addr;
    logic              rd_en;
    logic              nx_we;
    idx_t              nx_waddr;
    idx_t              nx_wdata;
    logic              pv_we;
    idx_t              pv_waddr;
    idx_t              pv_wdata;

    assign req_idx   = req_reg.handle[IDX_W-1:0];
    assign count_gt1 = (count_reg > CNT_W'(1));

    // Classify an incoming request against the current pool
    always_comb
    begin
        in_ok     = (int'(req_data.handle) < NUM_HANDLES);
        in_idx    = req_data.handle[IDX_W-1:0];
        in_member = in_ok && member_reg[in_idx];
        in_err    = ((req_data.cmd == CMD_PUT) && (!in_ok || in_member))
                 || ((req_data.cmd == CMD_REMOVE) && !in_member);
        in_empty  = ((req_data.cmd == CMD_GET) || (req_data.cmd == CMD_PEEK))
                 && (count_reg == '0);
    end

    // Request capture and working registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg   <= req_data;
            err_reg   <= in_err;
            empty_reg <= in_empty;
        end
        case (ctl.pick_sel)
            PICK_HEAD:   pick_reg <= head_reg;
            PICK_HANDLE: pick_reg <= req_idx;
            PICK_PREV:   pick_reg <= prev_rd_reg;
            default:     pick_reg <= pick_reg;
        endcase
        if (ctl.op == OP_PUT_NEW)
        begin
            last_reg <= prev_rd_reg;
        end
    end

    // Read address
    always_comb
    begin
        rd_en = (ctl.rd_sel != RD_NONE);
        unique case (ctl.rd_sel)
            RD_HEAD:   rd_addr = head_reg;
            RD_HANDLE: rd_addr = req_idx;
            RD_PREV:   rd_addr = prev_rd_reg;
            default:   rd_addr = head_reg;
        endcase
    end

    // Write ports: one write per link memory each cycle
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = req_idx;
        nx_wdata = req_idx;
        pv_we    = 1'b0;
        pv_waddr = req_idx;
        pv_wdata = req_idx;
        unique case (ctl.op)
            OP_PUT_SELF:
            begin
                // sole entry links to itself
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            OP_PUT_NEW:
            begin
                nx_we    = 1'b1;
                nx_wdata = head_reg;
                pv_we    = 1'b1;
                pv_wdata = prev_rd_reg;
            end
            OP_PUT_FIX:
            begin
                pv_we    = 1'b1;
                pv_waddr = head_reg;
                nx_we    = 1'b1;
                nx_waddr = last_reg;
            end
            OP_UNLINK:
            begin
                // neighbours close over the removed entry
                nx_we    = count_gt1;
                nx_waddr = prev_rd_reg;
                nx_wdata = next_rd_reg;
                pv_we    = count_gt1;
                pv_waddr = next_rd_reg;
                pv_wdata = prev_rd_reg;
            end
            default:
            begin
                nx_we = 1'b0;
            end
        endcase
    end

    // Link memories, registered read
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        if (rd_en)
        begin
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
        end
    end

    // Head, count and membership
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            member_reg <= '0;
        end
        else
        begin
            unique case (ctl.op)
                OP_PUT_SELF:
                begin
                    head_reg            <= req_idx;
                    count_reg           <= count_reg + CNT_W'(1);
                    member_reg[req_idx] <= 1'b1;
                end
                OP_PUT_FIX:
                begin
                    if (req_reg.at_front)
                    begin
                        head_reg <= req_idx;
                    end
                    count_reg           <= count_reg + CNT_W'(1);
                    member_reg[req_idx] <= 1'b1;
                end
                OP_UNLINK:
                begin
                    if (!count_gt1)
                    begin
                        head_reg <= '0;
                    end
                    else if (head_reg == pick_reg)
                    begin
                        head_reg <= next_rd_reg;
                    end
                    count_reg            <= count_reg - CNT_W'(1);
                    member_reg[pick_reg] <= 1'b0;
                end
                default:
                begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    // Result assembly
    always_comb
    begin
        is_ret              = ((req_reg.cmd == CMD_GET) || (req_reg.cmd == CMD_PEEK))
                           && !empty_reg;
        rsp_next.out_handle = is_ret ? HANDLE_W'(pick_reg) : '0;
        rsp_next.out_valid  = is_ret;
        rsp_next.status     = err_reg ? ST_MEMBER_ERR : (empty_reg ? ST_EMPTY : ST_OK);
        rsp_next.entries    = ENTRIES_W'(count_reg);
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Status to the controller
    always_comb
    begin
        stat.cmd        = req_reg.cmd;
        stat.front      = req_reg.at_front;
        stat.err        = err_reg;
        stat.empty      = empty_reg;
        stat.pool_empty = (count_reg == '0);
        stat.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

`default_nettype wire

[tb/linked_buffer_pool_manager_unit_tb.sv]
// Self-checking testbench for the linked buffer pool manager: table-driven and random requests
module linked_buffer_pool_manager_unit_tb;
    import lbpm_pkg::*;

    localparam int TABLE_ROWS  = 25;
    localparam int RAND_ITEMS  = 825;
    localparam int TOTAL_ITEMS = TABLE_ROWS + RAND_ITEMS;
    localparam int QUIET_FROM  = TOTAL_ITEMS - 100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 80;

    // One directed request; status and count are typed in only where typed is set
    typedef struct {
        logic [CMD_W-1:0]     cmd;
        logic [HANDLE_W-1:0]  handle;
        logic                 front;
        bit                   typed;
        logic [STATUS_W-1:0]  x_status;
        logic [ENTRIES_W-1:0] x_entries;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    // Shadow copy of the pool
    logic [HANDLE_W-1:0] link_next [MAX_HANDLES];
    logic [HANDLE_W-1:0] link_prev [MAX_HANDLES];
    bit                  in_pool   [MAX_HANDLES];
    logic [HANDLE_W-1:0] pool_head = '0;
    int                  pool_size = 0;

    rsp_t due_rsp_q [$];
    int   fault_count = 0;
    int   sent_count  = 0;
    int   rsp_checked = 0;
    int   op_seen [4] = '{0, 0, 0, 0};
    int   empty_seen  = 0;
    int   err_seen    = 0;
    int   peak_size   = 0;
    bit   quiet       = 1'b0;

    // Directed requests: empty pool, duplicates, head/middle/last unlinks, draining
    dir_row_t dir_rows [0:TABLE_ROWS-1] = '{
        '{CMD_GET,    6'd0,  1'b1, 1'b1, ST_EMPTY,      7'd0},
        '{CMD_PEEK,   6'd0,  1'b0, 1'b1, ST_EMPTY,      7'd0},
        '{CMD_REMOVE, 6'd63, 1'b1, 1'b1, ST_MEMBER_ERR, 7'd0},
        '{CMD_PUT,    6'd0,  1'b0, 1'b1, ST_OK,         7'd1},
        '{CMD_PUT,    6'd0,  1'b1, 1'b1, ST_MEMBER_ERR, 7'd1},
        '{CMD_PUT,    6'd63, 1'b1, 1'b1, ST_OK,         7'd2},
        '{CMD_PEEK,   6'd0,  1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_PEEK,   6'd63, 1'b0, 1'b0, ST_OK,         7'd0},
        '{CMD_PUT,    6'd42, 1'b0, 1'b0, ST_OK,         7'd0},
        '{CMD_PUT,    6'd21, 1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_REMOVE, 6'd21, 1'b0, 1'b0, ST_OK,         7'd0},
        '{CMD_REMOVE, 6'd0,  1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_REMOVE, 6'd0,  1'b0, 1'b1, ST_MEMBER_ERR, 7'd2},
        '{CMD_PUT,    6'd0,  1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_PUT,    6'd21, 1'b0, 1'b0, ST_OK,         7'd0},
        '{CMD_GET,    6'd63, 1'b0, 1'b0, ST_OK,         7'd0},
        '{CMD_GET,    6'd0,  1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_PEEK,   6'd0,  1'b0, 1'b0, ST_OK,         7'd0},
        '{CMD_GET,    6'd42, 1'b0, 1'b0, ST_OK,         7'd0},
        '{CMD_PEEK,   6'd0,  1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_GET,    6'd0,  1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_GET,    6'd0,  1'b0, 1'b1, ST_EMPTY,      7'd0},
        '{CMD_PUT,    6'd42, 1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_REMOVE, 6'd42, 1'b1, 1'b0, ST_OK,         7'd0},
        '{CMD_PEEK,   6'd21, 1'b1, 1'b1, ST_EMPTY,      7'd0}
    };

    linked_buffer_pool_manager_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Take a member out of the shadow ring
    function automatic void pool_unlink(input logic [HANDLE_W-1:0] h);
        logic [HANDLE_W-1:0] nx;
        logic [HANDLE_W-1:0] pv;
        nx = link_next[h];
        pv = link_prev[h];
        if (pool_size <= 1)
        begin
            pool_head = '0;
        end
        else
        begin
            link_prev[nx] = pv;
            link_next[pv] = nx;
            if (pool_head == h)
                pool_head = nx;
        end
        pool_size--;
        in_pool[h] = 1'b0;
    endfunction

    // Apply one request to the shadow pool and return the result it should give
    function automatic rsp_t pool_apply(input req_t r);
        rsp_t                res;
        logic [HANDLE_W-1:0] pick;
        logic [HANDLE_W-1:0] nx;
        logic [HANDLE_W-1:0] tail;
        res = '0;
        res.status = ST_OK;
        case (r.cmd) inside
            CMD_PUT:
            begin
                if (in_pool[r.handle])
                begin
                    res.status = ST_MEMBER_ERR;
                end
                else
                begin
                    if (pool_size == 0)
                    begin
                        link_next[r.handle] = r.handle;
                        link_prev[r.handle] = r.handle;
                        pool_head = r.handle;
                    end
                    else
                    begin
                        tail = link_prev[pool_head];
                        link_next[r.handle] = pool_head;
                        link_prev[r.handle] = tail;
                        link_prev[pool_head] = r.handle;
                        link_next[tail] = r.handle;
                        if (r.at_front)
                            pool_head = r.handle;
                    end
                    pool_size++;
                    in_pool[r.handle] = 1'b1;
                end
            end
            CMD_GET, CMD_PEEK:
            begin
                if (pool_size == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    pick = r.at_front ? pool_head : link_prev[pool_head];
                    res.out_handle = pick;
                    res.out_valid = 1'b1;
                    if (r.cmd == CMD_GET)
                    begin
                        // successor of the taken entry becomes head either way
                        nx = link_next[pick];
                        pool_unlink(pick);
                        if (pool_size != 0)
                            pool_head = nx;
                    end
                end
            end
            default:
            begin
                if (!in_pool[r.handle])
                    res.status = ST_MEMBER_ERR;
                else
                    pool_unlink(r.handle);
            end
        endcase
        res.entries = pool_size[ENTRIES_W-1:0];
        return res;
    endfunction

    // Offer one request, hold it until taken, then log what it should produce
    task automatic offer(input req_t r, input bit typed, input logic [STATUS_W-1:0] t_status,
                         input logic [ENTRIES_W-1:0] t_entries);
        rsp_t due;
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        due = pool_apply(r);
        if (typed)
        begin
            due = '0;
            due.status = t_status;
            due.entries = t_entries;
        end
        due_rsp_q.push_back(due);
        op_seen[r.cmd]++;
        if (due.status == ST_EMPTY)
            empty_seen++;
        if (due.status == ST_MEMBER_ERR)
            err_seen++;
        if (pool_size > peak_size)
            peak_size = pool_size;
        sent_count++;
        @(negedge clk);
    endtask

    // Reset, then the request stream: table first, random after
    initial
    begin
        req_t        r;
        int          roll;
        int          guard;
        bit          filling;
        logic [CMD_W-1:0]    op;
        logic [HANDLE_W-1:0] h;
        filling = 1'b1;
        foreach (in_pool[i])
            in_pool[i] = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int n = 0; n < TOTAL_ITEMS; n++)
        begin
            if (n < TABLE_ROWS)
            begin
                r.cmd      = dir_rows[n].cmd;
                r.handle   = dir_rows[n].handle;
                r.at_front = dir_rows[n].front;
                offer(r, dir_rows[n].typed, dir_rows[n].x_status, dir_rows[n].x_entries);
            end
            else
            begin
                // swing between filling and draining so full and empty pools are both reached
                if (pool_size == MAX_HANDLES)
                    filling = 1'b0;
                else if (pool_size == 0)
                    filling = 1'b1;
                else if ($urandom_range(0, 199) == 0)
                    filling = !filling;
                roll = $urandom_range(0, 99);
                if (filling)
                    op = (roll < 65) ? CMD_PUT : (roll < 80) ? CMD_GET :
                         (roll < 90) ? CMD_PEEK : CMD_REMOVE;
                else
                    op = (roll < 15) ? CMD_PUT : (roll < 60) ? CMD_GET :
                         (roll < 75) ? CMD_PEEK : CMD_REMOVE;
                h = HANDLE_W'($urandom_range(0, MAX_HANDLES - 1));
                // mostly well-formed: put a non-member, remove a member
                if ($urandom_range(0, 9) != 0)
                begin
                    if (op == CMD_PUT && pool_size < MAX_HANDLES)
                        while (in_pool[h])
                            h = HANDLE_W'($urandom_range(0, MAX_HANDLES - 1));
                    else if (op == CMD_REMOVE && pool_size > 0)
                        while (!in_pool[h])
                            h = HANDLE_W'($urandom_range(0, MAX_HANDLES - 1));
                end
                r.cmd      = op;
                r.handle   = h;
                r.at_front = 1'($urandom_range(0, 1));
                offer(r, 1'b0, ST_OK, '0);
            end
            if (sent_count >= QUIET_FROM)
                quiet = 1'b1;
            // sender gap
            if (!quiet && n < TOTAL_ITEMS - 1 && $urandom_range(0, 3) == 0)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
        req_valid <= 1'b0;

        // drain outstanding results, then allow for strays
        guard = 0;
        while (due_rsp_q.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (due_rsp_q.size() != 0)
        begin
            $display("%0d expected results never arrived", due_rsp_q.size());
            fault_count += due_rsp_q.size();
        end

        $display("Ran %0d requests (%0d put, %0d get, %0d peek, %0d remove), %0d results checked.",
                 sent_count, op_seen[CMD_PUT], op_seen[CMD_GET], op_seen[CMD_PEEK],
                 op_seen[CMD_REMOVE], rsp_checked);
        $display("Saw %0d empty-pool answers, %0d membership errors, pool peak %0d of %0d.",
                 empty_seen, err_seen, peak_size, MAX_HANDLES);
        if (fault_count == 0)
            $display("linked_buffer_pool_manager_unit verification clean");
        else
            $display("linked_buffer_pool_manager_unit verification failed");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off to back the block up
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && sent_count >= HOLD_AT)
            begin
                held = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_rsp_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("Unexpected result: handle %0d valid %0b status %0d entries %0d",
                             rsp_data.out_handle, rsp_data.out_valid, rsp_data.status,
                             rsp_data.entries);
            end
            else
            begin
                want = due_rsp_q.pop_front();
                rsp_checked++;
                if (rsp_data.out_handle !== want.out_handle ||
                    rsp_data.out_valid  !== want.out_valid  ||
                    rsp_data.status     !== want.status     ||
                    rsp_data.entries    !== want.entries)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $write("Result %0d mismatch: want h=%0d v=%0b st=%0d n=%0d,",
                               rsp_checked, want.out_handle, want.out_valid, want.status,
                               want.entries);
                        $display(" got h=%0d v=%0b st=%0d n=%0d",
                                 rsp_data.out_handle, rsp_data.out_valid,
                                 rsp_data.status, rsp_data.entries);
                    end
                end
            end
        end
    end

    // Overall time limit
    initial
    begin
        #400000;
        $display("linked_buffer_pool_manager_unit verification failed");
        $finish;
    end

endmodule

[linked_buffer_pool_manager_unit.f]
+incdir+design
design/lbpm_pkg.sv
design/lbpm_ctrl.sv
design/lbpm_dp.sv
design/linked_buffer_pool_manager_unit.sv
tb/linked_buffer_pool_manager_unit_tb.sv
